/* hw/rtl/ecb_pkg.sv */
// Shared types, constants and the blend function of the EWMA circuit breaker.
// Depends on nothing; imported by ewma_circuit_breaker_top, ecb_breaker_checker and testbench.
`default_nettype none

package ecb_pkg;

   localparam int LATENCY_W  = 24;
   localparam int RATE_W     = 17;
   localparam int WMARK_W    = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   // Smoothing weight alpha = 0.3 in Q0.16.
   localparam logic [15:0] ALPHA_Q16 = 16'd19661;

   // 1.0 in Q1.16, and the reset values of the limit registers.
   localparam logic [RATE_W-1:0]    ONE_Q16           = 17'd65536;
   localparam logic [LATENCY_W-1:0] LATENCY_LIMIT_RST = 24'hFFFFFF;

   typedef enum logic [1:0] {
      OP_LATENCY  = 2'd0,
      OP_ERROR    = 2'd1,
      OP_RESOURCE = 2'd2,
      OP_CHECK    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REASON_ACCEPT   = 2'd0,
      REASON_LATENCY  = 2'd1,
      REASON_ERROR    = 2'd2,
      REASON_RESOURCE = 2'd3
   } reason_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LATENCY_LIMIT  = 2'd0,
      CSR_ERROR_LIMIT    = 2'd1,
      CSR_RESOURCE_LIMIT = 2'd2,
      CSR_LIMITS_ENABLED = 2'd3
   } csr_index_type;

   // avg_new = (alpha*x + (1-alpha)*avg) >> 16, rewritten as
   // ((avg << 16) + alpha*(x - avg)) >> 16 so that one multiplier is enough.
   // The sum is never negative, so the floor of the shift matches exactly.
   function automatic logic [LATENCY_W-1:0] blend(input logic [LATENCY_W-1:0] x,
                                                 input logic [LATENCY_W-1:0] avg);
      logic signed [LATENCY_W:0]    diff;
      logic signed [LATENCY_W+17:0] diff_ext;
      logic signed [LATENCY_W+17:0] alpha_ext;
      logic signed [LATENCY_W+17:0] base_ext;
      logic signed [LATENCY_W+17:0] acc;
      diff      = $signed({1'b0, x}) - $signed({1'b0, avg});
      diff_ext  = (LATENCY_W+18)'(diff);
      alpha_ext = $signed({(LATENCY_W+2)'(0), ALPHA_Q16});
      base_ext  = $signed({2'b00, avg, 16'h0000});
      acc       = base_ext + diff_ext * alpha_ext;
      return acc[LATENCY_W+15:16];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ewma_circuit_breaker_top.sv */
// EWMA circuit breaker: input register, single-pass update logic, result register.
// Depends on ecb_pkg for field widths, codes and the blend function.
// A req word accepted goes first into the input register, then into the result
// register, from which its rsp word leaves.
// Throughput: one word per cycle; both stages advance whenever the result
// register is empty or being taken.
// Reset (synchronous, active high) clears averages, breaker, seen flag and both
// stages, sets the limits to full scale and disables them.
`default_nettype none

module ewma_circuit_breaker_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request stream.
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // tdata, low bit up: latency_sample[23:0], error_flag[24],
   // watermark_sample[42:25] (signed), zero fill [47:43].
   input  wire logic [ecb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: opcode[1:0].
   input  wire logic [1:0]                       req_tuser,
   // Response stream.
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata, low bit up: reason_code[1:0], breaker_open[2],
   // latency_baseline[26:3], error_baseline[43:27],
   // resource_baseline[60:44], zero fill [63:61].
   output      logic [ecb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: decision_valid[0].
   output      logic                             rsp_tuser,
   // Register write channel.
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [ecb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ecb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import ecb_pkg::*;

   // Limit registers.
   logic [LATENCY_W-1:0] lat_limit_ff;
   logic [RATE_W-1:0]    err_limit_ff;
   logic [RATE_W-1:0]    res_limit_ff;
   logic                 limits_en_ff;

   // Input stage.
   logic                 in_valid_ff;
   opcode_type           in_op_ff;
   logic [LATENCY_W-1:0] in_lat_ff;
   logic                 in_err_ff;
   logic [WMARK_W-1:0]   in_wmark_ff;

   // Running state.
   logic [LATENCY_W-1:0] avg_lat_ff,  avg_lat_in;
   logic [RATE_W-1:0]    avg_err_ff,  avg_err_in;
   logic [RATE_W-1:0]    avg_res_ff,  avg_res_in;
   logic                 seen_ff,     seen_in;
   logic                 open_ff,     open_in;

   // Result register.
   logic                 out_valid_ff;
   logic                 out_dec_ff,  out_dec_in;
   reason_type           out_reason_ff, reason_in;

   logic                 advance;
   logic [LATENCY_W-1:0] sample_x;
   logic [LATENCY_W-1:0] sample_avg;
   logic [LATENCY_W-1:0] blended;
   logic [LATENCY_W-1:0] new_avg;
   logic [RATE_W-1:0]    wmark_clamped;

   // The result register frees up when it is empty or its word is taken this cycle;
   // the input register can then always hand its word on.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Watermark is clamped to 0..1.0 in Q1.16 before it enters the average.
   always_comb begin
      priority if (in_wmark_ff[WMARK_W-1]) begin
         wmark_clamped = '0;
      end else if (in_wmark_ff[WMARK_W-2:0] > ONE_Q16) begin
         wmark_clamped = ONE_Q16;
      end else begin
         wmark_clamped = in_wmark_ff[RATE_W-1:0];
      end
   end

   // One blend unit serves all three averages; the opcode picks its operands.
   always_comb begin
      unique case (in_op_ff)
         OP_LATENCY: begin
            sample_x   = in_lat_ff;
            sample_avg = avg_lat_ff;
         end
         OP_ERROR: begin
            sample_x   = in_err_ff ? LATENCY_W'(ONE_Q16) : '0;
            sample_avg = LATENCY_W'(avg_err_ff);
         end
         OP_RESOURCE: begin
            sample_x   = LATENCY_W'(wmark_clamped);
            sample_avg = LATENCY_W'(avg_res_ff);
         end
         default: begin
            sample_x   = '0;
            sample_avg = '0;
         end
      endcase
   end

   assign blended = blend(sample_x, sample_avg);
   // The seen flag is shared by all three averages: only the very first sample
   // of any kind loads its average directly.
   assign new_avg = seen_ff ? blended : sample_x;

   always_comb begin
      avg_lat_in = avg_lat_ff;
      avg_err_in = avg_err_ff;
      avg_res_in = avg_res_ff;
      seen_in    = seen_ff;
      open_in    = open_ff;
      out_dec_in = 1'b0;
      reason_in  = REASON_ACCEPT;
      unique case (in_op_ff)
         OP_LATENCY: begin
            avg_lat_in = new_avg;
            seen_in    = 1'b1;
         end
         OP_ERROR: begin
            avg_err_in = new_avg[RATE_W-1:0];
            seen_in    = 1'b1;
         end
         OP_RESOURCE: begin
            avg_res_in = new_avg[RATE_W-1:0];
            seen_in    = 1'b1;
         end
         OP_CHECK: begin
            // Checks go in priority order; a trip needs the average strictly
            // above its limit, and disabled limits always accept.
            out_dec_in = 1'b1;
            if (limits_en_ff) begin
               priority if (avg_lat_ff > lat_limit_ff) begin
                  reason_in = REASON_LATENCY;
               end else if (avg_err_ff > err_limit_ff) begin
                  reason_in = REASON_ERROR;
               end else if (avg_res_ff > res_limit_ff) begin
                  reason_in = REASON_RESOURCE;
               end else begin
                  reason_in = REASON_ACCEPT;
               end
            end
            open_in = (reason_in != REASON_ACCEPT);
         end
         default: begin
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_limit_ff  <= LATENCY_LIMIT_RST;
         err_limit_ff  <= ONE_Q16;
         res_limit_ff  <= ONE_Q16;
         limits_en_ff  <= 1'b0;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         avg_lat_ff    <= '0;
         avg_err_ff    <= '0;
         avg_res_ff    <= '0;
         seen_ff       <= 1'b0;
         open_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_LATENCY_LIMIT:  lat_limit_ff <= csr_wdata;
               CSR_ERROR_LIMIT:    err_limit_ff <= csr_wdata[RATE_W-1:0];
               CSR_RESOURCE_LIMIT: res_limit_ff <= csr_wdata[RATE_W-1:0];
               CSR_LIMITS_ENABLED: limits_en_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               avg_lat_ff <= avg_lat_in;
               avg_err_ff <= avg_err_in;
               avg_res_ff <= avg_res_in;
               seen_ff    <= seen_in;
               open_ff    <= open_in;
            end
         end
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff    <= opcode_type'(req_tuser);
         in_lat_ff   <= req_tdata[LATENCY_W-1:0];
         in_err_ff   <= req_tdata[LATENCY_W];
         in_wmark_ff <= req_tdata[LATENCY_W+WMARK_W:LATENCY_W+1];
      end
      if (advance && in_valid_ff) begin
         out_dec_ff    <= out_dec_in;
         out_reason_ff <= reason_in;
      end
   end

   // The result word reports the state as it stands after its item, which is
   // exactly what the state registers hold while the word waits.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_dec_ff;
   assign rsp_tdata  = {3'b000, avg_res_ff, avg_err_ff, avg_lat_ff, open_ff, out_reason_ff};

   // Once any sample has arrived, averages blend from then on.
   a_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_ff |=> seen_ff)
      else $error("seen flag cleared after a sample");

   // Sample words carry no decision.
   a_sample_no_reason: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_dec_ff) |-> (out_reason_ff == REASON_ACCEPT))
      else $error("sample result carries a reason code");

   // A check result opens the breaker exactly when it rejects.
   a_open_matches_reason: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dec_ff) |-> (open_ff == (out_reason_ff != REASON_ACCEPT)))
      else $error("breaker state disagrees with reason code");

   // Rate averages stay within 0..1.0.
   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      (avg_err_ff <= ONE_Q16) && (avg_res_ff <= ONE_Q16))
      else $error("rate average above 1.0");

   // A stalled result holds the word in the input stage.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input word dropped while result stalled");

endmodule

`default_nettype wire

/* tb/ecb_breaker_checker.sv */
// Scoreboard for the EWMA circuit breaker: watches the request, response and
// register channels, predicts every response word and compares it. Uses ecb_pkg.
module ecb_breaker_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [ecb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [1:0]                       req_tuser,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [ecb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                             rsp_tuser,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [ecb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ecb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                    fail_count,
   output int                                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import ecb_pkg::*;

   localparam int unsigned WEIGHT_NEW  = 19661;
   localparam int unsigned WEIGHT_OLD  = 45875;
   localparam int          MAX_REPORTS = 10;

   typedef struct packed {
      logic              decision;
      reason_type        reason;
      logic              open;
      logic [23:0]       latency;
      logic [16:0]       error;
      logic [16:0]       resource;
      logic [2:0]        fill;
   } breaker_word_type;

   logic [23:0]       latency_limit_q;
   logic [16:0]       error_limit_q;
   logic [16:0]       resource_limit_q;
   logic              limits_on_q;
   logic [23:0]       latency_avg;
   logic [16:0]       error_avg;
   logic [16:0]       resource_avg;
   logic              seen_any;
   logic              breaker_open_q;
   breaker_word_type  expected_words[$];
   int                mismatches;
   int                word_count;

   function automatic logic [23:0] ewma_step(input logic [23:0] sample,
                                             input logic [23:0] avg);
      logic [41:0] acc;
      acc = 42'(sample) * 42'(WEIGHT_NEW) + 42'(avg) * 42'(WEIGHT_OLD);
      return acc[39:16];
   endfunction

   function automatic logic [16:0] clamp_watermark(input logic signed [17:0] raw);
      if (raw < 0)
         return '0;
      else if (raw > 18'sd65536)
         return ONE_Q16;
      else
         return raw[16:0];
   endfunction

   function automatic string show_word(input breaker_word_type w);
      return $sformatf("dv=%0d reason=%0d open=%0d lat=%06h err=%05h res=%05h fill=%0d",
                       w.decision, w.reason, w.open, w.latency, w.error, w.resource,
                       w.fill);
   endfunction

   // One shared flag decides whether a sample blends or loads its average.
   task automatic predict_word(input opcode_type op, input logic [REQ_DATA_W-1:0] data);
      breaker_word_type w;
      logic [16:0]      level;
      reason_type       why;
      why = REASON_ACCEPT;
      case (op)
         OP_LATENCY: begin
            latency_avg = seen_any ? ewma_step(data[23:0], latency_avg) : data[23:0];
            seen_any = 1'b1;
         end
         OP_ERROR: begin
            level = data[24] ? ONE_Q16 : '0;
            error_avg = seen_any ? 17'(ewma_step(24'(level), 24'(error_avg))) : level;
            seen_any = 1'b1;
         end
         OP_RESOURCE: begin
            level = clamp_watermark(data[42:25]);
            resource_avg = seen_any ? 17'(ewma_step(24'(level), 24'(resource_avg))) : level;
            seen_any = 1'b1;
         end
         default: begin
            if (limits_on_q) begin
               if (latency_avg > latency_limit_q)
                  why = REASON_LATENCY;
               else if (error_avg > error_limit_q)
                  why = REASON_ERROR;
               else if (resource_avg > resource_limit_q)
                  why = REASON_RESOURCE;
            end
            breaker_open_q = (why != REASON_ACCEPT);
         end
      endcase
      w.decision = (op == OP_CHECK);
      w.reason   = why;
      w.open     = breaker_open_q;
      w.latency  = latency_avg;
      w.error    = error_avg;
      w.resource = resource_avg;
      w.fill     = '0;
      expected_words.push_back(w);
   endtask

   always @(posedge clock) begin : monitor
      breaker_word_type got;
      breaker_word_type want;
      if (reset) begin
         latency_limit_q  = LATENCY_LIMIT_RST;
         error_limit_q    = ONE_Q16;
         resource_limit_q = ONE_Q16;
         limits_on_q      = 1'b0;
         latency_avg      = '0;
         error_avg        = '0;
         resource_avg     = '0;
         seen_any         = 1'b0;
         breaker_open_q   = 1'b0;
         mismatches       = 0;
         word_count       = 0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LATENCY_LIMIT:  latency_limit_q  = csr_wdata[23:0];
               CSR_ERROR_LIMIT:    error_limit_q    = csr_wdata[16:0];
               CSR_RESOURCE_LIMIT: resource_limit_q = csr_wdata[16:0];
               CSR_LIMITS_ENABLED: limits_on_q      = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_word(opcode_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.decision = rsp_tuser;
            got.reason   = reason_type'(rsp_tdata[1:0]);
            got.open     = rsp_tdata[2];
            got.latency  = rsp_tdata[26:3];
            got.error    = rsp_tdata[43:27];
            got.resource = rsp_tdata[60:44];
            got.fill     = rsp_tdata[63:61];
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("rsp word %0d arrived with nothing expected: %s",
                           word_count, show_word(got));
            end else begin
               want = expected_words.pop_front();
               if (got.decision != want.decision || got.reason != want.reason ||
                   got.open != want.open || got.latency != want.latency ||
                   got.error != want.error || got.resource != want.resource ||
                   got.fill != want.fill) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("rsp word %0d mismatch, expected %s", word_count,
                              show_word(want));
                     $display("rsp word %0d mismatch, actual   %s", word_count,
                              show_word(got));
                  end
               end
            end
            word_count++;
         end
      end
      fail_count <= mismatches;
      pending    <= expected_words.size();
   end

endmodule

/* tb/testbench.sv */
// Top of the EWMA circuit breaker testbench: clock, reset, stimulus, watchdog
// and verdict. Depends on ecb_pkg, ewma_circuit_breaker_top and ecb_breaker_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ecb_pkg::*;

   localparam int RESET_CYCLES   = 9;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_WORDS    = 228;
   localparam int REGIME_LEN     = 24;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   // tdata, low bit up: latency_sample[23:0], error_flag[24],
   // watermark_sample[42:25], zero fill [47:43].
   logic [REQ_DATA_W-1:0]    req_tdata;
   // tuser: opcode[1:0].
   logic [1:0]               req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   // tdata, low bit up: reason_code[1:0], breaker_open[2], latency_baseline[26:3],
   // error_baseline[43:27], resource_baseline[60:44], zero fill [63:61].
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   // tuser: decision_valid[0].
   logic                     rsp_tuser;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   int fail_count;
   int pending;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // The random traffic drifts through regimes: each regime fixes a center and a
   // spread for the samples, so the averages wander across the limits instead of
   // settling on the middle of the range.
   logic [23:0] lat_center;
   int          lat_bits;
   int          err_pct;
   logic [16:0] wm_center;
   int          wm_bits;

   ewma_circuit_breaker_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ecb_breaker_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The receiver decides anew at every falling edge whether it takes a word.
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // The watchdog counts cycles in which no word moves on any channel. A correct
   // run never comes near the limit, even with the heaviest stalling phase.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   // Offers one request word and returns at the rising edge that takes it. The
   // valid stays high afterwards, so back-to-back words follow without a gap.
   task automatic push_request(input opcode_type op, input logic [23:0] lat,
                               input logic err, input logic [17:0] wm);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {5'b0, wm, err, lat};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops sending and waits until the checker has seen every response. Every
   // request gives exactly one response, so the block is idle afterwards.
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [23:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Writes all four registers while the block is idle. Bits above a register's
   // width carry random values; the block must ignore them.
   task automatic program_limits(input logic [23:0] lat, input logic [16:0] err,
                                 input logic [16:0] res, input logic enable);
      drain_responses();
      write_register(CSR_LATENCY_LIMIT, lat);
      write_register(CSR_ERROR_LIMIT, {7'($urandom), err});
      write_register(CSR_RESOURCE_LIMIT, {7'($urandom), res});
      write_register(CSR_LIMITS_ENABLED, {23'($urandom), enable});
   endtask

   task automatic next_regime();
      lat_center = 24'($urandom);
      lat_bits   = $urandom_range(0, 24);
      err_pct    = $urandom_range(0, 100);
      wm_center  = 17'($urandom_range(0, 65536));
      wm_bits    = $urandom_range(0, 16);
   endtask

   task automatic random_request();
      logic [23:0] lat_mask;
      logic [16:0] wm_mask;
      logic [23:0] lat;
      logic [17:0] wm;
      lat_mask = 24'((32'd1 << lat_bits) - 1);
      wm_mask  = 17'((32'd1 << wm_bits) - 1);
      lat = (lat_center & ~lat_mask) | (24'($urandom) & lat_mask);
      case ($urandom_range(9))
         0:       wm = 18'($urandom);                      // anything, negatives too
         1:       wm = 18'($urandom_range(65536, 131071)); // above full scale
         default: wm = {1'b0, (wm_center & ~wm_mask) | (17'($urandom) & wm_mask)};
      endcase
      push_request(opcode_type'($urandom_range(3)), lat,
                   ($urandom_range(99) < err_pct), wm);
   endtask

   initial begin : stimulus
      logic [17:0] wm_corners[7];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OP_LATENCY;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_LATENCY_LIMIT;
      csr_wdata  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, limits at their reset values. A check before any sample
      // sees all averages at zero. The first sample of the run loads its average
      // directly; every later one blends, whatever kind it is.
      push_request(OP_CHECK, 24'($urandom), 1'($urandom), 18'($urandom));
      push_request(OP_LATENCY, 24'hFFFFFF, 1'($urandom), 18'($urandom));
      push_request(OP_LATENCY, 24'h000000, 1'($urandom), 18'($urandom));
      push_request(OP_ERROR, 24'($urandom), 1'b1, 18'($urandom));
      push_request(OP_ERROR, 24'($urandom), 1'b0, 18'($urandom));
      // Watermark corners: most negative, minus one, zero, full scale, just
      // above full scale, most positive, and one value inside the range.
      wm_corners = '{18'h20000, 18'h3FFFF, 18'h00000, 18'h10000, 18'h10001,
                     18'h1FFFF, 18'h08000};
      foreach (wm_corners[i])
         push_request(OP_RESOURCE, 24'($urandom), 1'($urandom), wm_corners[i]);
      push_request(OP_CHECK, 24'($urandom), 1'($urandom), 18'($urandom));

      // Each reason in turn. After the two latency samples above the latency
      // average is 11743999, so a limit equal to it must not trip while one
      // below it must.
      program_limits(24'd0, ONE_Q16, ONE_Q16, 1'b1);
      push_request(OP_CHECK, 24'($urandom), 1'($urandom), 18'($urandom));
      program_limits(24'd11743999, ONE_Q16, ONE_Q16, 1'b1);
      push_request(OP_CHECK, 24'($urandom), 1'($urandom), 18'($urandom));
      program_limits(24'd11743998, ONE_Q16, ONE_Q16, 1'b1);
      push_request(OP_CHECK, 24'($urandom), 1'($urandom), 18'($urandom));
      program_limits(24'hFFFFFF, 17'd0, ONE_Q16, 1'b1);
      push_request(OP_CHECK, 24'($urandom), 1'($urandom), 18'($urandom));
      program_limits(24'hFFFFFF, ONE_Q16, 17'd0, 1'b1);
      push_request(OP_CHECK, 24'($urandom), 1'($urandom), 18'($urandom));
      // A sample while the breaker is open must report it still open.
      push_request(OP_LATENCY, 24'($urandom), 1'($urandom), 18'($urandom));
      // Limits above full scale can never trip; the breaker closes again.
      program_limits(24'hFFFFFF, 17'h1FFFF, 17'h1FFFF, 1'b1);
      push_request(OP_CHECK, 24'($urandom), 1'($urandom), 18'($urandom));

      // Random phases. Each one programs a new setting of the limits and picks
      // one of the idling modes, so gaps and stalls land on every stage.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: program_limits(24'hFFFFFF, ONE_Q16, ONE_Q16, 1'b0);
            2: program_limits(24'd0, 17'd0, 17'd0, 1'b1);
            3: program_limits(24'hFFFFFF, 17'h1FFFF, 17'h1FFFF, 1'b1);
            6: program_limits(24'($urandom), 17'($urandom_range(0, 65536)),
                              17'($urandom_range(0, 65536)), 1'b0);
            default: program_limits(24'($urandom), 17'($urandom_range(0, 65536)),
                                    17'($urandom_range(0, 65536)), 1'b1);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (i % REGIME_LEN == 0)
               next_regime();
            // Halfway through, the sender holds off until the pipeline is empty,
            // so the next word enters a block with no work in flight.
            if (i == PHASE_WORDS / 2)
               drain_responses();
            random_request();
         end
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
